### design/beat_phase_tracker_macros.svh
// Assertion macros for the beat phase tracker.
// Included by the files that check their own logic; no other dependencies.
`ifndef BEAT_PHASE_TRACKER_MACROS_SVH
`define BEAT_PHASE_TRACKER_MACROS_SVH

`ifndef SYNTHESIS
`define BPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`define BPT_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define BPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`define BPT_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### design/bpt_pkg.sv
// Shared types and constants for the beat phase tracker.
// Used by bpt_dp, bpt_ctrl and beat_phase_tracker; no dependencies.
`timescale 1ns / 1ps

package bpt_pkg;

  localparam int unsigned TimeWidthDef = 64;
  localparam int unsigned FracBits     = 8;

  localparam logic CmdFrame   = 1'b0;
  localparam logic CmdControl = 1'b1;

  localparam int unsigned FlagTimeRef = 0;
  localparam int unsigned FlagTempo   = 1;
  localparam int unsigned FlagProgram = 2;

  typedef struct packed {
    logic        cmd;
    logic [63:0] now_us;
    logic [2:0]  update_flags;
    logic [63:0] new_time_ref;
    logic [31:0] sync_beat_count;
    logic [31:0] new_period;
    logic [7:0]  new_program;
  } in_t;

  typedef struct packed {
    logic        active;
    logic [7:0]  fraction;
    logic [31:0] pattern_count;
    logic        beat_seen;
    logic [7:0]  program_res;
  } out_t;

  typedef struct packed {
    logic ld_item;
    logic ref_upd;
    logic tempo_upd;
    logic prog_upd;
    logic chk;
    logic div_init;
    logic div_step;
    logic win_next;
    logic win_last;
    logic frac_init;
    logic frac_spec;
    logic frac_step;
    logic cnt_upd;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic active;
    logic need_step;
    logic div_last;
    logic frac_zero;
    logic frac_full;
    logic frac_last;
    logic out_free;
  } dp_stat_t;

endpackage

### design/bpt_dp.sv
// Datapath: beat state, remainder divider, fraction unit and result register.
// Depends on bpt_pkg; driven by bpt_ctrl.
`timescale 1ns / 1ps

module bpt_dp #(
  parameter int unsigned TIME_WIDTH = bpt_pkg::TimeWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bpt_pkg::in_t       in_i,
  input  bpt_pkg::ctl_cmd_t  cmd_i,
  output bpt_pkg::dp_stat_t  stat_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bpt_pkg::out_t      out_o
);

  localparam int unsigned TW   = TIME_WIDTH;
  localparam int unsigned CntW = $clog2(TIME_WIDTH);
  localparam int unsigned FcW  = $clog2(bpt_pkg::FracBits);

  logic [TW-1:0] ref_q, last_q, next_q;
  logic [31:0]   period_q, counter_q, pending_q;
  logic [7:0]    prog_q, prev_q;
  logic          out_valid_q;

  logic [TW-1:0] now_q, tref_q;
  logic [2:0]    flags_q;
  logic [31:0]   sync_q, nper_q;
  logic [7:0]    nprog_q;
  logic [31:0]   shown_q;
  logic [7:0]    acc_q;
  logic          seen_q, fact_q;
  logic [TW-1:0] d_q, part_q, whole_q;
  logic [31:0]   rem_q;
  logic [CntW-1:0] div_cnt_q;
  logic [FcW-1:0]  frac_cnt_q;
  bpt_pkg::out_t   out_q;

  logic [TW-1:0] per_ext, nper_ext, ref_last, next_adj, adj, half;
  logic [32:0]   sh, sh_sub;
  logic          sh_ge, bit_ge, seen_now, tempo_start;
  logic [31:0]   rem_nxt, inc;

  assign per_ext     = TW'(period_q);
  assign nper_ext    = TW'(nper_q);
  assign ref_last    = last_q - tref_q + next_q;
  assign sh          = {rem_q, d_q[TW-1]};
  assign sh_sub      = sh - {1'b0, period_q};
  assign sh_ge       = sh >= {1'b0, period_q};
  assign rem_nxt     = sh_ge ? sh_sub[31:0] : sh[31:0];
  assign adj         = (rem_q != '0) ? TW'(period_q - rem_q) : '0;
  assign next_adj    = now_q + adj;
  assign half        = whole_q >> 1;
  assign bit_ge      = part_q >= half;
  assign inc         = counter_q + 32'd1;
  assign seen_now    = prev_q > acc_q;
  assign tempo_start = (ref_q == '0) && (nper_q != '0);

  assign stat_o.active    = (ref_q != '0) && (period_q != '0);
  assign stat_o.need_step = next_q < now_q;
  assign stat_o.div_last  = div_cnt_q == '0;
  assign stat_o.frac_zero = whole_q == '0;
  assign stat_o.frac_full = part_q >= whole_q;
  assign stat_o.frac_last = frac_cnt_q == FcW'(bpt_pkg::FracBits - 1);
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q       <= '0;
      last_q      <= '0;
      next_q      <= '0;
      period_q    <= '0;
      counter_q   <= '0;
      pending_q   <= '0;
      prog_q      <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.ref_upd && flags_q[bpt_pkg::FlagTimeRef]) begin
        ref_q     <= tref_q;
        last_q    <= ref_last;
        next_q    <= tref_q;
        pending_q <= sync_q;
      end
      if (cmd_i.tempo_upd && flags_q[bpt_pkg::FlagTempo]) begin
        period_q <= nper_q;
        if (tempo_start) begin
          ref_q  <= now_q;
          last_q <= now_q;
          next_q <= now_q + nper_ext;
        end
      end
      if (cmd_i.prog_upd && flags_q[bpt_pkg::FlagProgram]) begin
        prog_q <= nprog_q;
      end
      if (cmd_i.win_next) begin
        next_q <= next_adj;
      end
      if (cmd_i.win_last) begin
        last_q <= next_q - per_ext;
      end
      if (cmd_i.cnt_upd) begin
        prev_q <= acc_q;
        if (seen_now) begin
          counter_q <= (pending_q > inc) ? pending_q : inc;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_item) begin
      now_q   <= in_i.now_us[TW-1:0];
      tref_q  <= in_i.new_time_ref[TW-1:0];
      flags_q <= in_i.update_flags;
      sync_q  <= in_i.sync_beat_count;
      nper_q  <= in_i.new_period;
      nprog_q <= in_i.new_program;
      shown_q <= counter_q;
      acc_q   <= '0;
      seen_q  <= 1'b0;
      fact_q  <= 1'b0;
    end
    if (cmd_i.chk) begin
      fact_q <= stat_o.active;
    end
    if (cmd_i.div_init) begin
      d_q       <= now_q - next_q;
      rem_q     <= '0;
      div_cnt_q <= CntW'(TW - 1);
    end
    if (cmd_i.div_step) begin
      rem_q     <= rem_nxt;
      d_q       <= d_q << 1;
      div_cnt_q <= div_cnt_q - 1'b1;
    end
    if (cmd_i.frac_init) begin
      part_q     <= now_q - last_q;
      whole_q    <= next_q - last_q;
      frac_cnt_q <= '0;
    end
    if (cmd_i.frac_spec) begin
      acc_q <= stat_o.frac_zero ? 8'h00 : 8'hFF;
    end
    if (cmd_i.frac_step) begin
      whole_q    <= half;
      acc_q      <= {acc_q[6:0], bit_ge};
      frac_cnt_q <= frac_cnt_q + 1'b1;
      if (bit_ge) begin
        part_q <= part_q - half;
      end
    end
    if (cmd_i.cnt_upd && seen_now) begin
      seen_q <= 1'b1;
    end
    if (cmd_i.out_load) begin
      out_q.active        <= fact_q;
      out_q.fraction      <= acc_q;
      out_q.pattern_count <= shown_q;
      out_q.beat_seen     <= seen_q;
      out_q.program_res   <= prog_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

### design/bpt_ctrl.sv
// Controller: sequences control updates and frame processing in bpt_dp.
// Depends on bpt_pkg and beat_phase_tracker_macros.svh.
`timescale 1ns / 1ps
`include "beat_phase_tracker_macros.svh"

module bpt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_cmd_i,
  output logic               in_stall_o,
  input  bpt_pkg::dp_stat_t  stat_i,
  output bpt_pkg::ctl_cmd_t  cmd_o
);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SCref  = 4'd1;
  localparam logic [3:0] SCtmp  = 4'd2;
  localparam logic [3:0] SCprg  = 4'd3;
  localparam logic [3:0] SFchk  = 4'd4;
  localparam logic [3:0] SFdiv  = 4'd5;
  localparam logic [3:0] SFadj  = 4'd6;
  localparam logic [3:0] SFlast = 4'd7;
  localparam logic [3:0] SFinit = 4'd8;
  localparam logic [3:0] SFspec = 4'd9;
  localparam logic [3:0] SFbits = 4'd10;
  localparam logic [3:0] SFcnt  = 4'd11;
  localparam logic [3:0] SDone  = 4'd12;

  logic [3:0] state_q, state_d;

  assign in_stall_o = state_q != SIdle;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.ld_item = 1'b1;
          state_d = (in_cmd_i == bpt_pkg::CmdControl) ? SCref : SFchk;
        end
      end
      SCref: begin
        cmd_o.ref_upd = 1'b1;
        state_d = SCtmp;
      end
      SCtmp: begin
        cmd_o.tempo_upd = 1'b1;
        state_d = SCprg;
      end
      SCprg: begin
        cmd_o.prog_upd = 1'b1;
        state_d = SDone;
      end
      SFchk: begin
        cmd_o.chk = 1'b1;
        if (!stat_i.active) begin
          state_d = SDone;
        end else if (stat_i.need_step) begin
          cmd_o.div_init = 1'b1;
          state_d = SFdiv;
        end else begin
          state_d = SFinit;
        end
      end
      SFdiv: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = SFadj;
        end
      end
      SFadj: begin
        cmd_o.win_next = 1'b1;
        state_d = SFlast;
      end
      SFlast: begin
        cmd_o.win_last = 1'b1;
        state_d = SFinit;
      end
      SFinit: begin
        cmd_o.frac_init = 1'b1;
        state_d = SFspec;
      end
      SFspec: begin
        if (stat_i.frac_zero || stat_i.frac_full) begin
          cmd_o.frac_spec = 1'b1;
          state_d = SFcnt;
        end else begin
          state_d = SFbits;
        end
      end
      SFbits: begin
        cmd_o.frac_step = 1'b1;
        if (stat_i.frac_last) begin
          state_d = SFcnt;
        end
      end
      SFcnt: begin
        cmd_o.cnt_upd = 1'b1;
        state_d = SDone;
      end
      SDone: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  `BPT_ASSERT_NEXT(a_div_hold, clk_i, rst_ni, (state_q == SFdiv) && !stat_i.div_last, state_q == SFdiv, "divider left before last step")
  `BPT_ASSERT_NEXT(a_inactive_skip, clk_i, rst_ni, (state_q == SFchk) && !stat_i.active, state_q == SDone, "inactive frame not sent to result")
  `BPT_ASSERT_NEXT(a_done_release, clk_i, rst_ni, (state_q == SDone) && stat_i.out_free, state_q == SIdle, "result not released when output free")
  `BPT_ASSERT_SAME(a_div_active, clk_i, rst_ni, state_q == SFdiv, stat_i.active, "dividing with zero period or reference")

endmodule

### design/beat_phase_tracker.sv
// Flow from accepted item to result valid: a control item runs the reference, tempo and
// program updates; an inactive frame goes straight to the result; an active frame steps
// the window in the divider if needed (one remainder bit per cycle), then one fraction bit
// per cycle, skipped for an empty or full window. Output stalls delay the result of each.
// Throughput: one item at a time; the next item is taken the cycle after the result loads.
// Reset: rst_ni clears all beat state, program and count to zero, no clearing pass.
`timescale 1ns / 1ps

module beat_phase_tracker #(
  parameter int unsigned TIME_WIDTH = bpt_pkg::TimeWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bpt_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bpt_pkg::out_t out_o
);

  bpt_pkg::ctl_cmd_t ctl_cmd;
  bpt_pkg::dp_stat_t dp_stat;

  bpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_i.cmd),
    .in_stall_o (in_stall_o),
    .stat_i     (dp_stat),
    .cmd_o      (ctl_cmd)
  );

  bpt_dp #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (ctl_cmd),
    .stat_o      (dp_stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

### tb/sv/beat_phase_tracker_tb.sv
// Self-checking bench for beat_phase_tracker: directed, back-pressure and random song tests.
// Tracks beat state in bench-side variables and checks every result item field by field.
// Depends on bpt_pkg and the beat_phase_tracker RTL only.
`timescale 1ns / 1ps

module beat_phase_tracker_tb;

  localparam int unsigned ItemTarget = 1050;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned TailCycles = 120;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned PrintCap   = 40;
  localparam logic [63:0] HalfSpan   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] AllOnes    = 64'hFFFF_FFFF_FFFF_FFFF;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  bpt_pkg::in_t  in_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  bpt_pkg::out_t out_o;

  // Beat state as the block should hold it
  logic [63:0] trk_ref_time = '0;
  logic [63:0] trk_last_beat = '0;
  logic [63:0] trk_next_beat = '0;
  logic [31:0] trk_period = '0;
  logic [31:0] trk_count = '0;
  logic [31:0] trk_pending = '0;
  logic [7:0]  trk_program = '0;
  logic [7:0]  trk_prev_frac = '0;

  bpt_pkg::out_t phase_reports_q[$];

  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_hold_left = 0;
  int unsigned rx_stall_left = 0;
  bit          idle_on = 1'b1;
  logic [63:0] song_clock = 64'd1_000_000;

  beat_phase_tracker uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("beat_phase_tracker test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < PrintCap) begin
      $display("MISMATCH at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  function automatic logic [7:0] frac_of(logic [63:0] part, logic [63:0] whole);
    logic [7:0] acc;
    acc = '0;
    if (whole == 64'd0) return 8'd0;
    if (part >= whole) return 8'hFF;
    for (int b = 0; b < 8; b++) begin
      whole = whole >> 1;
      if (part >= whole) begin
        acc[7 - b] = 1'b1;
        part = part - whole;
      end
    end
    return acc;
  endfunction

  function automatic bpt_pkg::out_t track_item(bpt_pkg::in_t it);
    bpt_pkg::out_t r;
    logic [63:0] span_us;
    logic [63:0] steps;
    logic [7:0]  f;
    r = '0;
    if (it.cmd == bpt_pkg::CmdControl) begin
      if (it.update_flags[bpt_pkg::FlagTimeRef]) begin
        trk_ref_time = it.new_time_ref;
        trk_last_beat = trk_last_beat - (it.new_time_ref - trk_next_beat);
        trk_next_beat = it.new_time_ref;
        trk_pending = it.sync_beat_count;
      end
      if (it.update_flags[bpt_pkg::FlagTempo]) begin
        trk_period = it.new_period;
        if (trk_ref_time == 64'd0 && trk_period != 32'd0) begin
          trk_ref_time = it.now_us;
          trk_last_beat = it.now_us;
          trk_next_beat = it.now_us + {32'd0, trk_period};
        end
      end
      if (it.update_flags[bpt_pkg::FlagProgram]) begin
        trk_program = it.new_program;
      end
      r.pattern_count = trk_count;
    end else if (trk_ref_time != 64'd0 && trk_period != 32'd0) begin
      r.active = 1'b1;
      if (trk_next_beat < it.now_us) begin
        span_us = it.now_us - trk_next_beat;
        steps = span_us / {32'd0, trk_period};
        if (span_us % {32'd0, trk_period} != 64'd0) steps = steps + 64'd1;
        trk_next_beat = trk_next_beat + steps * {32'd0, trk_period};
        trk_last_beat = trk_next_beat - {32'd0, trk_period};
      end
      f = frac_of(it.now_us - trk_last_beat, trk_next_beat - trk_last_beat);
      r.fraction = f;
      r.pattern_count = trk_count;
      if (trk_prev_frac > f) begin
        r.beat_seen = 1'b1;
        trk_count = trk_count + 32'd1;
        if (trk_pending > trk_count) trk_count = trk_pending;
      end
      trk_prev_frac = f;
    end else begin
      r.pattern_count = trk_count;
    end
    r.program_res = trk_program;
    return r;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!idle_on || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stall runs, and a long hold when the output hold test arms one
  always @(negedge clk_i) begin
    if (rx_hold_left != 0) begin
      rx_hold_left = rx_hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (rx_stall_left != 0) begin
      rx_stall_left = rx_stall_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      rx_stall_left = idle_len();
      out_stall_i <= (rx_stall_left != 0);
      if (rx_stall_left != 0) rx_stall_left = rx_stall_left - 1;
    end
  end

  always @(posedge clk_i) begin : check_results
    bpt_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (phase_reports_q.size() == 0) begin
        report_mismatch("result with none pending", 64'(out_o), 64'd0);
      end else begin
        want = phase_reports_q.pop_front();
        if (out_o.active !== want.active)
          report_mismatch("active", 64'(out_o.active), 64'(want.active));
        if (out_o.fraction !== want.fraction)
          report_mismatch("fraction", 64'(out_o.fraction), 64'(want.fraction));
        if (out_o.pattern_count !== want.pattern_count)
          report_mismatch("pattern_count", 64'(out_o.pattern_count),
                          64'(want.pattern_count));
        if (out_o.beat_seen !== want.beat_seen)
          report_mismatch("beat_seen", 64'(out_o.beat_seen), 64'(want.beat_seen));
        if (out_o.program_res !== want.program_res)
          report_mismatch("program_res", 64'(out_o.program_res), 64'(want.program_res));
      end
    end
  end

  task automatic send_item(input bpt_pkg::in_t it);
    int unsigned gap;
    gap = idle_len();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    phase_reports_q.push_back(track_item(it));
    items_sent++;
  endtask

  task automatic wait_all_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (phase_reports_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic bpt_pkg::in_t frame_item(logic [63:0] now);
    bpt_pkg::in_t it;
    it = '0;
    it.cmd = bpt_pkg::CmdFrame;
    it.now_us = now;
    it.update_flags = 3'($urandom);
    it.new_time_ref = {$urandom, $urandom};
    it.sync_beat_count = $urandom;
    it.new_period = $urandom;
    it.new_program = 8'($urandom);
    return it;
  endfunction

  function automatic bpt_pkg::in_t control_item(logic [2:0] flags, logic [63:0] now,
                                                logic [63:0] tref, logic [31:0] sync,
                                                logic [31:0] period, logic [7:0] prog);
    bpt_pkg::in_t it;
    it.cmd = bpt_pkg::CmdControl;
    it.now_us = now;
    it.update_flags = flags;
    it.new_time_ref = tref;
    it.sync_beat_count = sync;
    it.new_period = period;
    it.new_program = prog;
    return it;
  endfunction

  function automatic bpt_pkg::in_t noise_item();
    bpt_pkg::in_t it;
    it.cmd = 1'($urandom_range(0, 1));
    it.now_us = {$urandom, $urandom};
    it.update_flags = 3'($urandom_range(0, 7));
    it.new_time_ref = ($urandom_range(0, 3) == 0) ? 64'd0 : {$urandom, $urandom};
    it.sync_beat_count = $urandom;
    it.new_period = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
    it.new_program = 8'($urandom);
    return it;
  endfunction

  function automatic logic [31:0] pick_period();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return 32'd0;
    if (roll < 12) return $urandom_range(1, 15);
    if (roll < 75) return $urandom_range(16, 5000);
    if (roll < 92) return $urandom_range(5001, 1 << 20);
    return $urandom;
  endfunction

  task automatic test_directed_cases();
    logic [2:0] f_ref;
    logic [2:0] f_tempo;
    logic [2:0] f_prog;
    f_ref = '0;
    f_ref[bpt_pkg::FlagTimeRef] = 1'b1;
    f_tempo = '0;
    f_tempo[bpt_pkg::FlagTempo] = 1'b1;
    f_prog = '0;
    f_prog[bpt_pkg::FlagProgram] = 1'b1;
    idle_on = 1'b1;
    // inactive frames straight after reset
    send_item(frame_item(64'd0));
    send_item(frame_item(AllOnes));
    send_item(control_item(3'b000, {$urandom, $urandom}, {$urandom, $urandom},
                           $urandom, $urandom, 8'($urandom)));
    send_item(control_item(f_prog, 64'd0, 64'd0, 32'd0, 32'd0, 8'hFF));
    // zero tempo must not start timing
    send_item(control_item(f_tempo, 64'd77, 64'd0, 32'd0, 32'd0, 8'd0));
    // reference move leaves an empty window
    send_item(control_item(f_ref, 64'd0, HalfSpan, 32'hFFFF_FFFF, 32'd0, 8'd0));
    send_item(control_item(f_tempo, 64'd5, 64'd0, 32'd0, 32'd1000, 8'd0));
    send_item(frame_item(HalfSpan - 64'd5));
    send_item(frame_item(HalfSpan + 64'd2500));
    send_item(frame_item(HalfSpan + 64'd3000));
    // wrap raises count to armed value
    send_item(frame_item(HalfSpan + 64'd3001));
    // now before last beat
    send_item(frame_item(HalfSpan + 64'd1000));
    send_item(frame_item(HalfSpan + 64'd3500));
    send_item(control_item(f_ref | f_prog, 64'd0, HalfSpan + 64'd5000, 32'd0, 32'd0, 8'h00));
    send_item(frame_item(HalfSpan + 64'd4000));
    // beat counter wraps through zero
    send_item(frame_item(HalfSpan + 64'd5200));
    send_item(control_item(f_tempo, 64'd0, 64'd0, 32'd0, 32'hFFFF_FFFF, 8'd0));
    send_item(frame_item(AllOnes));
    send_item(control_item(f_ref, 64'd0, 64'd0, 32'd0, 32'd0, 8'd0));
    send_item(frame_item(64'd123));
    // restart at top of time range, next beat wraps to zero
    send_item(control_item(3'b111, AllOnes, 64'd0, 32'd3, 32'd1, 8'h5A));
    send_item(frame_item(AllOnes));
    send_item(control_item(f_tempo, 64'd0, 64'd0, 32'd0, 32'd0, 8'd0));
    send_item(frame_item({$urandom, $urandom}));
  endtask

  task automatic test_output_hold();
    logic [2:0] flags;
    wait_all_results();
    @(posedge clk_i);
    idle_on = 1'b0;
    rx_hold_left = HoldCycles;
    flags = '0;
    flags[bpt_pkg::FlagTempo] = 1'b1;
    flags[bpt_pkg::FlagTimeRef] = 1'b1;
    send_item(control_item(flags, song_clock, 64'd0, 32'd0, 32'd2000, 8'd0));
    repeat (8) begin
      song_clock += $urandom_range(1, 700);
      send_item(frame_item(song_clock));
    end
    wait_all_results();
  endtask

  task automatic test_beat_songs();
    logic [31:0] period;
    logic [2:0]  flags;
    while (items_sent < ItemTarget) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 6)) send_item(noise_item());
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          song_clock = {$urandom, $urandom};
        end else if ($urandom_range(0, 19) == 0) begin
          song_clock = AllOnes - $urandom_range(0, 50000);
        end
        period = pick_period();
        flags = '0;
        flags[bpt_pkg::FlagTempo] = 1'b1;
        flags[bpt_pkg::FlagProgram] = 1'($urandom_range(0, 1));
        flags[bpt_pkg::FlagTimeRef] = ($urandom_range(0, 2) == 0);
        send_item(control_item(flags, song_clock, 64'd0, $urandom, period, 8'($urandom)));
        repeat ($urandom_range(4, 30)) begin
          case ($urandom_range(0, 19))
            0: song_clock -= $urandom_range(1, period / 2 + 1);
            1: song_clock += {32'd0, $urandom} << $urandom_range(0, 24);
            2: begin
              flags = 3'($urandom_range(0, 7));
              flags[bpt_pkg::FlagTimeRef] = 1'b1;
              send_item(control_item(flags, song_clock,
                                     song_clock + $urandom_range(0, period),
                                     ($urandom_range(0, 3) == 0) ? $urandom
                                                                 : $urandom_range(0, 64),
                                     period, 8'($urandom)));
            end
            default: song_clock += $urandom_range(1, period / 3 + 1);
          endcase
          send_item(frame_item(song_clock));
        end
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_output_hold();
    test_beat_songs();
    wait_all_results();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("beat_phase_tracker test passed");
    end else begin
      $display("beat_phase_tracker test failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/bpt_pkg.sv
design/bpt_dp.sv
design/bpt_ctrl.sv
design/beat_phase_tracker.sv
tb/sv/beat_phase_tracker_tb.sv
